/* src/vrd_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vrd_pkg: shared types and constants for the degree-based vector rotator
// Widths, angle constants, gain and the CORDIC arctangent table in Q.24 degrees.
// ----------------------------------------------------------------------------
package vrd_pkg;

   localparam int IN_W           = 32;  // vector component width, Q15.16
   localparam int ANG_W          = 16;  // angle width, Q9.6 degrees
   localparam int NEG_W          = IN_W + 1;
   localparam int RED_W          = 18;  // angle reduction arithmetic
   localparam int RES_W          = 14;  // residual angle, within +/-90 deg
   localparam int ZW             = 33;  // angle accumulator, Q.24 degrees
   localparam int ACC_W          = 52;  // x/y datapath with guard bits
   localparam int GAIN_W         = 31;
   localparam int PROD_W         = NEG_W + GAIN_W + 1;
   localparam int GAIN_SHIFT     = 15;
   localparam int GUARD_BITS     = 16;
   localparam int ANGLE_UP_SHIFT = 18;
   localparam int ATAN_W         = 30;
   localparam int MAX_STAGES     = 32;
   localparam int CORDIC_STAGES_DEF = 20;

   localparam logic [GAIN_W-1:0] GAIN_INV_Q31 = 31'd1304065748;

   localparam logic signed [RED_W-1:0] FULL_TURN    = 18'sd23040;
   localparam logic signed [RED_W-1:0] TWO_TURNS    = 18'sd46080;
   localparam logic signed [RED_W-1:0] HALF_TURN    = 18'sd11520;
   localparam logic signed [RED_W-1:0] QUARTER_TURN = 18'sd5760;

   localparam logic [ATAN_W-1:0] ATAN_Q24 [MAX_STAGES] = '{
      30'd754974720, 30'd445687602, 30'd235489088, 30'd119537938,
      30'd60000934,  30'd30029717,  30'd15018523,  30'd7509720,
      30'd3754917,   30'd1877466,   30'd938734,    30'd469367,
      30'd234684,    30'd117342,    30'd58671,     30'd29335,
      30'd14668,     30'd7334,      30'd3667,      30'd1833,
      30'd917,       30'd458,       30'd229,       30'd115,
      30'd57,        30'd29,        30'd14,        30'd7,
      30'd4,         30'd2,         30'd1,         30'd0
   };

   // After angle reduction: vector possibly negated, residual angle in Q7.6
   typedef struct packed {
      logic signed [NEG_W-1:0] x;
      logic signed [NEG_W-1:0] y;
      logic signed [RES_W-1:0] r;
   } vrd_prep_type;

   // CORDIC working set
   typedef struct packed {
      logic signed [ACC_W-1:0] x;
      logic signed [ACC_W-1:0] y;
      logic signed [ZW-1:0]    z;
   } vrd_cordic_type;

endpackage

/* src/vrd_prep.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vrd_prep: angle reduction stage
// Reduces the angle modulo 360 degrees, folds it into +/-90 degrees and
// negates the vector when a half-turn pre-rotation is taken.
// ----------------------------------------------------------------------------
module vrd_prep (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              in_valid,
   output logic                              in_ready,
   input  logic signed [vrd_pkg::IN_W-1:0]   in_x,
   input  logic signed [vrd_pkg::IN_W-1:0]   in_y,
   input  logic signed [vrd_pkg::ANG_W-1:0]  in_angle,
   output logic                              out_valid,
   input  logic                              out_ready,
   output vrd_pkg::vrd_prep_type             out_data
);
   import vrd_pkg::*;

   logic                    valid_ff, valid_in;
   vrd_prep_type            data_ff, data_in;
   logic signed [RED_W-1:0] ang_ext, mod_r, half_r, fold_r;
   logic                    negate;
   logic signed [NEG_W-1:0] x_ext, y_ext;

   assign in_ready  = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign out_data  = data_ff;

   always_comb begin
      ang_ext = RED_W'(in_angle);
      if (ang_ext < -FULL_TURN) begin
         mod_r = ang_ext + TWO_TURNS;
      end else if (ang_ext < 0) begin
         mod_r = ang_ext + FULL_TURN;
      end else if (ang_ext >= FULL_TURN) begin
         mod_r = ang_ext - FULL_TURN;
      end else begin
         mod_r = ang_ext;
      end
      half_r = (mod_r >= HALF_TURN) ? mod_r - FULL_TURN : mod_r;
      // fold into +/-90 degrees by an exact half-turn
      if (half_r > QUARTER_TURN) begin
         negate = 1'b1;
         fold_r = half_r - HALF_TURN;
      end else if (half_r < -QUARTER_TURN) begin
         negate = 1'b1;
         fold_r = half_r + HALF_TURN;
      end else begin
         negate = 1'b0;
         fold_r = half_r;
      end
      x_ext     = NEG_W'(in_x);
      y_ext     = NEG_W'(in_y);
      data_in.x = negate ? -x_ext : x_ext;
      data_in.y = negate ? -y_ext : y_ext;
      data_in.r = fold_r[RES_W-1:0];
      valid_in  = in_ready ? in_valid : valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (in_valid && in_ready) begin
         data_ff <= data_in;
      end
   end

endmodule

/* src/vrd_gain.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vrd_gain: gain compensation stage
// Scales both components by 1/K and widens to the guarded datapath; lifts
// the residual angle to Q.24 degrees.
// ----------------------------------------------------------------------------
module vrd_gain (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    in_valid,
   output logic                    in_ready,
   input  vrd_pkg::vrd_prep_type   in_data,
   output logic                    out_valid,
   input  logic                    out_ready,
   output vrd_pkg::vrd_cordic_type out_data
);
   import vrd_pkg::*;

   logic                     valid_ff, valid_in;
   vrd_cordic_type           data_ff, data_in;
   logic signed [PROD_W-1:0] prod_x, prod_y;
   logic signed [GAIN_W:0]   gain_s;
   logic signed [ZW-1:0]     z_ext;

   assign in_ready  = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign out_data  = data_ff;

   always_comb begin
      gain_s    = $signed({1'b0, GAIN_INV_Q31});
      prod_x    = PROD_W'(in_data.x) * PROD_W'(gain_s);
      prod_y    = PROD_W'(in_data.y) * PROD_W'(gain_s);
      data_in.x = ACC_W'(prod_x >>> GAIN_SHIFT);
      data_in.y = ACC_W'(prod_y >>> GAIN_SHIFT);
      z_ext     = ZW'(in_data.r);
      data_in.z = z_ext <<< ANGLE_UP_SHIFT;
      valid_in  = in_ready ? in_valid : valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (in_valid && in_ready) begin
         data_ff <= data_in;
      end
   end

endmodule

/* src/vrd_cordic_stage.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vrd_cordic_stage: one CORDIC micro-rotation
// Rotates by +/-atan(2^-SHIFT) toward zero residual angle, one register stage.
// ----------------------------------------------------------------------------
module vrd_cordic_stage #(
   parameter int SHIFT = 0
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    in_valid,
   output logic                    in_ready,
   input  vrd_pkg::vrd_cordic_type in_data,
   output logic                    out_valid,
   input  logic                    out_ready,
   output vrd_pkg::vrd_cordic_type out_data
);
   import vrd_pkg::*;

   localparam logic signed [ZW-1:0] STEP_ANGLE = ZW'(ATAN_Q24[SHIFT]);

   logic                    valid_ff, valid_in;
   vrd_cordic_type          data_ff, data_in;
   logic signed [ACC_W-1:0] dx, dy;

   assign in_ready  = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign out_data  = data_ff;

   always_comb begin
      dx = in_data.y >>> SHIFT;
      dy = in_data.x >>> SHIFT;
      if (!in_data.z[ZW-1]) begin
         data_in.x = in_data.x - dx;
         data_in.y = in_data.y + dy;
         data_in.z = in_data.z - STEP_ANGLE;
      end else begin
         data_in.x = in_data.x + dx;
         data_in.y = in_data.y - dy;
         data_in.z = in_data.z + STEP_ANGLE;
      end
      valid_in = in_ready ? in_valid : valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (in_valid && in_ready) begin
         data_ff <= data_in;
      end
   end

endmodule

/* src/vrd_round.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vrd_round: output stage
// Drops the guard bits with round-half-up, clips to 32 bits and flags clipping.
// ----------------------------------------------------------------------------
module vrd_round (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             in_valid,
   output logic                             in_ready,
   input  vrd_pkg::vrd_cordic_type          in_data,
   output logic                             out_valid,
   input  logic                             out_ready,
   output logic signed [vrd_pkg::IN_W-1:0]  out_x,
   output logic signed [vrd_pkg::IN_W-1:0]  out_y,
   output logic                             out_sat
);
   import vrd_pkg::*;

   localparam logic signed [ACC_W-1:0] HALF_LSB = ACC_W'(1) <<< (GUARD_BITS - 1);
   localparam logic signed [ACC_W-1:0] OUT_MAX  =
      $signed({{(ACC_W-IN_W+1){1'b0}}, {(IN_W-1){1'b1}}});
   localparam logic signed [ACC_W-1:0] OUT_MIN  =
      $signed({{(ACC_W-IN_W+1){1'b1}}, {(IN_W-1){1'b0}}});

   logic                    valid_ff, valid_in;
   logic signed [IN_W-1:0]  x_ff, y_ff, x_in, y_in;
   logic                    sat_ff, sat_in;
   logic signed [ACC_W-1:0] rx, ry;
   logic                    hit_x, hit_y;

   assign in_ready  = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign out_x     = x_ff;
   assign out_y     = y_ff;
   assign out_sat   = sat_ff;

   always_comb begin
      rx = (in_data.x + HALF_LSB) >>> GUARD_BITS;
      ry = (in_data.y + HALF_LSB) >>> GUARD_BITS;
      hit_x = 1'b1;
      hit_y = 1'b1;
      if (rx > OUT_MAX) begin
         x_in = OUT_MAX[IN_W-1:0];
      end else if (rx < OUT_MIN) begin
         x_in = OUT_MIN[IN_W-1:0];
      end else begin
         x_in  = rx[IN_W-1:0];
         hit_x = 1'b0;
      end
      if (ry > OUT_MAX) begin
         y_in = OUT_MAX[IN_W-1:0];
      end else if (ry < OUT_MIN) begin
         y_in = OUT_MIN[IN_W-1:0];
      end else begin
         y_in  = ry[IN_W-1:0];
         hit_y = 1'b0;
      end
      sat_in   = hit_x || hit_y;
      valid_in = in_ready ? in_valid : valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (in_valid && in_ready) begin
         x_ff   <= x_in;
         y_ff   <= y_in;
         sat_ff <= sat_in;
      end
   end

endmodule

/* src/vector_rotate_by_degrees.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vector_rotate_by_degrees: pipelined CORDIC vector rotator
// Rotates a Q15.16 vector counterclockwise by a Q9.6 angle in degrees,
// with saturation of the result.
//
//   channel   ports       direction   contents
//   request   req_*       in          vec_x, vec_y, angle_deg
//   response  rsp_*       out         rot_x, rot_y, saturated
//
// The pipeline has one stage each for angle reduction, gain multiply and
// rounding, plus one per micro-rotation (capped at 32 micro-rotations).
// One beat is taken every cycle while the response side keeps up. Each
// stage has its own valid bit and holds while the next one is full and
// stalled, so bubbles close up and no beat is lost or repeated.
// Reset is synchronous and empties the pipeline.
// ----------------------------------------------------------------------------
module vector_rotate_by_degrees #(
   parameter int CORDIC_STAGES = vrd_pkg::CORDIC_STAGES_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic signed [vrd_pkg::IN_W-1:0]  req_vec_x,
   input  logic signed [vrd_pkg::IN_W-1:0]  req_vec_y,
   input  logic signed [vrd_pkg::ANG_W-1:0] req_angle_deg,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic signed [vrd_pkg::IN_W-1:0]  rsp_rot_x,
   output logic signed [vrd_pkg::IN_W-1:0]  rsp_rot_y,
   output logic                             rsp_saturated
);
   import vrd_pkg::*;

   localparam int NUM_ROT = (CORDIC_STAGES > MAX_STAGES) ? MAX_STAGES : CORDIC_STAGES;
   localparam int DEPTH   = NUM_ROT + 3;
   localparam int CNT_W   = $clog2(DEPTH + 1);

   vrd_prep_type   prep_data;
   logic           prep_valid, prep_ready;
   vrd_cordic_type rot_data  [NUM_ROT+1];
   logic           rot_valid [NUM_ROT+1];
   logic           rot_ready [NUM_ROT+1];

   vrd_prep u_prep (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_ready  (req_ready),
      .in_x      (req_vec_x),
      .in_y      (req_vec_y),
      .in_angle  (req_angle_deg),
      .out_valid (prep_valid),
      .out_ready (prep_ready),
      .out_data  (prep_data)
   );

   vrd_gain u_gain (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (prep_valid),
      .in_ready  (prep_ready),
      .in_data   (prep_data),
      .out_valid (rot_valid[0]),
      .out_ready (rot_ready[0]),
      .out_data  (rot_data[0])
   );

   for (genvar i = 0; i < NUM_ROT; i++) begin : g_rot
      vrd_cordic_stage #(
         .SHIFT (i)
      ) u_stage (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (rot_valid[i]),
         .in_ready  (rot_ready[i]),
         .in_data   (rot_data[i]),
         .out_valid (rot_valid[i+1]),
         .out_ready (rot_ready[i+1]),
         .out_data  (rot_data[i+1])
      );
   end

   vrd_round u_round (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (rot_valid[NUM_ROT]),
      .in_ready  (rot_ready[NUM_ROT]),
      .in_data   (rot_data[NUM_ROT]),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .out_x     (rsp_rot_x),
      .out_y     (rsp_rot_y),
      .out_sat   (rsp_saturated)
   );

   // beats in flight, for checking only
   logic [CNT_W-1:0] inflight_ff, inflight_in;

   always_comb begin
      inflight_in = inflight_ff;
      if ((req_valid && req_ready) && !(rsp_valid && rsp_ready)) begin
         inflight_in = inflight_ff + CNT_W'(1);
      end else if (!(req_valid && req_ready) && (rsp_valid && rsp_ready)) begin
         inflight_in = inflight_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         inflight_ff <= '0;
      end else begin
         inflight_ff <= inflight_in;
      end
   end

   a_sat_clipped : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_saturated |->
         rsp_rot_x == 32'sh7FFFFFFF || rsp_rot_x == 32'sh80000000 ||
         rsp_rot_y == 32'sh7FFFFFFF || rsp_rot_y == 32'sh80000000)
      else $error("saturated flag without a clipped component");

   a_stall_source : assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> rsp_valid && !rsp_ready)
      else $error("request held off without a stalled response");

   a_inflight_cap : assert property (@(posedge clock) disable iff (reset)
      inflight_ff <= CNT_W'(DEPTH))
      else $error("more beats in flight than pipeline stages");

   a_no_phantom : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> inflight_ff != '0)
      else $error("response with no beat in flight");

   a_reset_empty : assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid right after reset");

endmodule
